/* rtl/lfpg_pkg.sv */
// ----------------------------------------------------------------------------
// LED flash pattern generator package
// Shared widths, register indexes, mode codes and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lfpg_pkg;

	// Width of the stored time registers and the interval; the elapsed
	// counter carries one bit more.
	localparam int TIME_WIDTH    = 16;
	localparam int ELAPSED_WIDTH = TIME_WIDTH + 1;
	localparam int MODE_WIDTH    = 4;
	localparam int STEP_WIDTH    = 3;
	localparam int ADDR_WIDTH    = 4;
	localparam int DATA_WIDTH    = 32;
	localparam int FIELD_WIDTH   = 16;

	// Register indexes (byte address divided by four).
	localparam logic [1:0] REG_MODE        = 2'd0;
	localparam logic [1:0] REG_ON_TIME     = 2'd1;
	localparam logic [1:0] REG_REPEAT_TIME = 2'd2;

	// Mode codes.
	localparam logic [MODE_WIDTH-1:0] MODE_OFF        = 4'd0;
	localparam logic [MODE_WIDTH-1:0] MODE_ON         = 4'd1;
	localparam logic [MODE_WIDTH-1:0] MODE_BLINK      = 4'd2;
	localparam logic [MODE_WIDTH-1:0] MODE_FLASH1     = 4'd3;
	localparam logic [MODE_WIDTH-1:0] MODE_FLASH2     = 4'd4;
	localparam logic [MODE_WIDTH-1:0] MODE_FLASH3     = 4'd5;
	localparam logic [MODE_WIDTH-1:0] MODE_INV_FLASH1 = 4'd6;
	localparam logic [MODE_WIDTH-1:0] MODE_INV_FLASH2 = 4'd7;
	localparam logic [MODE_WIDTH-1:0] MODE_INV_FLASH3 = 4'd8;

	// Toggle counts of the one, two and three flash bursts.
	localparam logic [STEP_WIDTH-1:0] PULSES_ONE   = 3'd1;
	localparam logic [STEP_WIDTH-1:0] PULSES_TWO   = 3'd3;
	localparam logic [STEP_WIDTH-1:0] PULSES_THREE = 3'd5;

	localparam logic [TIME_WIDTH-1:0] ON_TIME_RESET     = TIME_WIDTH'(100);
	localparam logic [TIME_WIDTH-1:0] REPEAT_TIME_RESET = TIME_WIDTH'(1000);

	typedef struct packed {
		logic [MODE_WIDTH-1:0] mode;
		logic [TIME_WIDTH-1:0] on_time;
		logic [TIME_WIDTH-1:0] repeat_time;
		logic                  restart;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/lfpg_regs.sv */
// ----------------------------------------------------------------------------
// LED flash pattern generator registers
// APB-style register file for mode, on time and repeat time.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [lfpg_pkg::ADDR_WIDTH-1:0] paddr,
	input  wire logic [lfpg_pkg::DATA_WIDTH-1:0] pwdata,
	output logic      [lfpg_pkg::DATA_WIDTH-1:0] prdata,
	output logic                                pready,
	output lfpg_pkg::cfg_t                      cfg
);
	import lfpg_pkg::*;

	logic [MODE_WIDTH-1:0] mode_q;
	logic [TIME_WIDTH-1:0] on_time_q;
	logic [TIME_WIDTH-1:0] repeat_time_q;
	logic                  restart_q;
	logic                  wr_en;
	logic [1:0]            reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_WIDTH-1:2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_OFF;
			on_time_q     <= ON_TIME_RESET;
			repeat_time_q <= REPEAT_TIME_RESET;
			restart_q     <= 1'b0;
		end else begin
			restart_q <= 1'b0;
			if (wr_en) begin
				unique case (reg_idx)
					REG_MODE: begin
						mode_q    <= pwdata[MODE_WIDTH-1:0];
						restart_q <= 1'b1;
					end
					REG_ON_TIME: begin
						on_time_q <= TIME_WIDTH'(pwdata[FIELD_WIDTH-1:0]);
						restart_q <= 1'b1;
					end
					REG_REPEAT_TIME: begin
						repeat_time_q <= TIME_WIDTH'(pwdata[FIELD_WIDTH-1:0]);
						restart_q     <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MODE:        prdata = DATA_WIDTH'(mode_q);
			REG_ON_TIME:     prdata = DATA_WIDTH'(on_time_q);
			REG_REPEAT_TIME: prdata = DATA_WIDTH'(repeat_time_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg = '{mode: mode_q, on_time: on_time_q, repeat_time: repeat_time_q,
		restart: restart_q};

endmodule

`default_nettype wire

/* rtl/lfpg_core.sv */
// ----------------------------------------------------------------------------
// LED flash pattern generator core
// Input register, pattern state update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpg_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire lfpg_pkg::cfg_t                 cfg,
	input  wire logic                           item_valid,
	output logic                                item_stall,
	input  wire logic                           tick,
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output logic                                led_level,
	output logic                                level_updated,
	output logic      [lfpg_pkg::STEP_WIDTH-1:0] pulse_step
);
	import lfpg_pkg::*;

	logic                     valid_s1;
	logic                     tick_s1;
	logic                     advance;

	logic [ELAPSED_WIDTH-1:0] elapsed_q;
	logic [TIME_WIDTH-1:0]    interval_q;
	logic [STEP_WIDTH-1:0]    toggles_q;
	logic                     led_q;
	logic                     started_q;

	logic [ELAPSED_WIDTH-1:0] elapsed_d;
	logic [TIME_WIDTH-1:0]    interval_d;
	logic [STEP_WIDTH-1:0]    toggles_d;
	logic                     led_d;
	logic                     fired_d;

	logic [ELAPSED_WIDTH-1:0] elapsed_inc;
	logic [STEP_WIDTH-1:0]    pulses;
	logic                     rest_level;
	logic                     is_flash;
	logic [TIME_WIDTH+2:0]    busy;
	logic [TIME_WIDTH-1:0]    rest_gap;

	// Stage one moves on whenever the result register is free or being taken.
	assign advance    = ~result_valid | ~result_stall;
	assign item_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall) begin
			tick_s1 <= tick;
		end
	end

	always_comb begin
		is_flash   = 1'b1;
		pulses     = PULSES_ONE;
		rest_level = 1'b0;
		unique case (cfg.mode)
			MODE_FLASH1:     pulses = PULSES_ONE;
			MODE_FLASH2:     pulses = PULSES_TWO;
			MODE_FLASH3:     pulses = PULSES_THREE;
			MODE_INV_FLASH1: begin
				pulses     = PULSES_ONE;
				rest_level = 1'b1;
			end
			MODE_INV_FLASH2: begin
				pulses     = PULSES_TWO;
				rest_level = 1'b1;
			end
			MODE_INV_FLASH3: begin
				pulses     = PULSES_THREE;
				rest_level = 1'b1;
			end
			default: is_flash = 1'b0;
		endcase
	end

	// Toggle counts are 1, 3 or 5, so the busy time is a shift and an add.
	always_comb begin
		unique case (pulses)
			PULSES_TWO:   busy = ({3'b0, cfg.on_time} << 1) + {3'b0, cfg.on_time};
			PULSES_THREE: busy = ({3'b0, cfg.on_time} << 2) + {3'b0, cfg.on_time};
			default:      busy = {3'b0, cfg.on_time};
		endcase
		if ({3'b0, cfg.repeat_time} > busy) begin
			rest_gap = cfg.repeat_time - busy[TIME_WIDTH-1:0];
		end else begin
			rest_gap = '0;
		end
	end

	always_comb begin
		elapsed_d  = elapsed_q;
		interval_d = interval_q;
		toggles_d  = toggles_q;
		led_d      = led_q;
		fired_d    = 1'b0;
		if (tick_s1 && !(&elapsed_q)) begin
			elapsed_inc = elapsed_q + 1'b1;
		end else begin
			elapsed_inc = elapsed_q;
		end
		if (!started_q) begin
			// The first item after a restart only starts the sequence.
			elapsed_d  = '0;
			interval_d = '0;
			led_d      = 1'b0;
		end else if (elapsed_inc > {1'b0, interval_q}) begin
			elapsed_d = '0;
			fired_d   = 1'b1;
			if (is_flash) begin
				if (toggles_q == '0) begin
					interval_d = rest_gap;
					toggles_d  = pulses;
					led_d      = rest_level;
				end else begin
					interval_d = cfg.on_time;
					led_d      = ~led_q;
					toggles_d  = toggles_q - 1'b1;
				end
			end else begin
				unique case (cfg.mode)
					MODE_OFF: begin
						led_d      = 1'b0;
						interval_d = cfg.repeat_time;
					end
					MODE_ON: begin
						led_d      = 1'b1;
						interval_d = cfg.repeat_time;
					end
					MODE_BLINK: begin
						led_d      = ~led_q;
						interval_d = cfg.repeat_time >> 1;
					end
					default: begin
					end
				endcase
			end
		end else begin
			elapsed_d = elapsed_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q    <= '0;
			interval_q   <= '0;
			toggles_q    <= '0;
			led_q        <= 1'b0;
			started_q    <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (advance) begin
				result_valid <= valid_s1;
			end
			if (cfg.restart) begin
				started_q <= 1'b0;
				toggles_q <= '0;
				led_q     <= 1'b0;
			end else if (valid_s1 && advance) begin
				started_q  <= 1'b1;
				elapsed_q  <= elapsed_d;
				interval_q <= interval_d;
				toggles_q  <= toggles_d;
				led_q      <= led_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			led_level     <= led_d;
			level_updated <= fired_d;
			pulse_step    <= toggles_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/led_flash_pattern_generator.sv */
// ----------------------------------------------------------------------------
// LED flash pattern generator
// Tick-driven LED pattern sequencer with an APB-style configuration port.
// ----------------------------------------------------------------------------
// Each item carries one tick flag and produces exactly one result item with
// the LED level, a flag that the pattern stepped, and the toggles left in the
// current flash burst. An item lands in the input register at the edge that
// accepts it, and its result moves on into the result register once that
// register is free or being taken. A new item is accepted every cycle unless
// a stalled result holds the result register; the elapsed counter compare
// and the state update sit between the two registers. Registers sit at
// byte addresses 0 (mode), 4 (on time) and 8 (repeat time). A write to one
// of these registers restarts the sequence, so the first item after it only starts
// the pattern and reports level_updated low. Write the registers only while
// no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module led_flash_pattern_generator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Configuration port.
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [lfpg_pkg::ADDR_WIDTH-1:0] paddr,
	input  wire logic [lfpg_pkg::DATA_WIDTH-1:0] pwdata,
	output logic      [lfpg_pkg::DATA_WIDTH-1:0] prdata,
	output logic                                pready,
	// Input items.
	input  wire logic                           item_valid,
	output logic                                item_stall,
	input  wire logic                           tick,
	// Result items.
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output logic                                led_level,
	output logic                                level_updated,
	output logic      [lfpg_pkg::STEP_WIDTH-1:0] pulse_step
);
	import lfpg_pkg::*;

	// Register values and the one-cycle restart pulse of a write.
	cfg_t cfg;

	lfpg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The core holds the pattern state and both pipeline registers.
	lfpg_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.tick          (tick),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.led_level     (led_level),
		.level_updated (level_updated),
		.pulse_step    (pulse_step)
	);

endmodule

`default_nettype wire

/* tb/led_pattern_check_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED pattern tracker
// Follows the generator's state from accepted items and register writes, and
// checks each result item in order against the level it should report.
// ----------------------------------------------------------------------------
package led_pattern_check_pkg;
	import lfpg_pkg::*;

	typedef struct packed {
		logic                  led;
		logic                  updated;
		logic [STEP_WIDTH-1:0] step;
	} led_result_t;

	class led_pattern_tracker;
		logic [MODE_WIDTH-1:0]    cur_mode;
		logic [TIME_WIDTH-1:0]    on_ticks;
		logic [TIME_WIDTH-1:0]    repeat_ticks;
		logic [ELAPSED_WIDTH-1:0] elapsed;
		logic [TIME_WIDTH-1:0]    interval;
		logic [STEP_WIDTH-1:0]    toggles;
		logic                     led_on;
		bit                       running;
		led_result_t              expected_levels[$];
		int unsigned              items_noted;
		int unsigned              results_checked;
		int unsigned              steps_fired;
		int unsigned              error_count;

		function new();
			cur_mode        = MODE_OFF;
			on_ticks        = ON_TIME_RESET;
			repeat_ticks    = REPEAT_TIME_RESET;
			elapsed         = '0;
			interval        = '0;
			toggles         = '0;
			led_on          = 1'b0;
			running         = 1'b0;
			items_noted     = 0;
			results_checked = 0;
			steps_fired     = 0;
			error_count     = 0;
		endfunction

		// Any write to a known register restarts the sequence.
		function void write_register(logic [1:0] index, logic [DATA_WIDTH-1:0] value);
			case (index)
			REG_MODE:        cur_mode = value[MODE_WIDTH-1:0];
			REG_ON_TIME:     on_ticks = TIME_WIDTH'(value[FIELD_WIDTH-1:0]);
			REG_REPEAT_TIME: repeat_ticks = TIME_WIDTH'(value[FIELD_WIDTH-1:0]);
			default:         return;
			endcase
			running = 1'b0;
			toggles = '0;
			led_on  = 1'b0;
		endfunction

		// A burst starts with the rest gap, then each pulse toggles the LED.
		function void flash_burst(logic [STEP_WIDTH-1:0] pulses, logic rest_level);
			int unsigned busy;
			if (toggles == '0) begin
				busy     = int'(pulses) * int'(on_ticks);
				interval = (int'(repeat_ticks) > busy) ?
					TIME_WIDTH'(int'(repeat_ticks) - busy) : '0;
				toggles  = pulses;
				led_on   = rest_level;
			end else begin
				interval = on_ticks;
				led_on   = ~led_on;
				toggles  = toggles - 1'b1;
			end
		endfunction

		function void advance_pattern();
			case (cur_mode)
			MODE_OFF: begin
				led_on   = 1'b0;
				interval = repeat_ticks;
			end
			MODE_ON: begin
				led_on   = 1'b1;
				interval = repeat_ticks;
			end
			MODE_BLINK: begin
				led_on   = ~led_on;
				interval = repeat_ticks >> 1;
			end
			MODE_FLASH1:     flash_burst(PULSES_ONE, 1'b0);
			MODE_FLASH2:     flash_burst(PULSES_TWO, 1'b0);
			MODE_FLASH3:     flash_burst(PULSES_THREE, 1'b0);
			MODE_INV_FLASH1: flash_burst(PULSES_ONE, 1'b1);
			MODE_INV_FLASH2: flash_burst(PULSES_TWO, 1'b1);
			MODE_INV_FLASH3: flash_burst(PULSES_THREE, 1'b1);
			// Codes past the last mode step without touching level or interval.
			default: ;
			endcase
		endfunction

		function void note_tick(logic tick_in);
			led_result_t want;
			want.updated = 1'b0;
			if (!running) begin
				running  = 1'b1;
				elapsed  = '0;
				interval = '0;
				led_on   = 1'b0;
			end else begin
				if (tick_in && elapsed != '1)
					elapsed = elapsed + 1'b1;
				if (elapsed > ELAPSED_WIDTH'(interval)) begin
					elapsed = '0;
					advance_pattern();
					want.updated = 1'b1;
					steps_fired++;
				end
			end
			want.led  = led_on;
			want.step = toggles;
			expected_levels.push_back(want);
			items_noted++;
		endfunction

		function void check_level(logic led, logic updated, logic [STEP_WIDTH-1:0] step);
			led_result_t want;
			results_checked++;
			if (expected_levels.size() == 0) begin
				$error("result with none outstanding: led_level %0d level_updated %0d pulse_step %0d",
					led, updated, step);
				error_count++;
				return;
			end
			want = expected_levels.pop_front();
			if (led !== want.led) begin
				$error("led_level: expected %0d, actual %0d", want.led, led);
				error_count++;
			end
			if (updated !== want.updated) begin
				$error("level_updated: expected %0d, actual %0d", want.updated, updated);
				error_count++;
			end
			if (step !== want.step) begin
				$error("pulse_step: expected %0d, actual %0d", want.step, step);
				error_count++;
			end
		endfunction

		function int pending();
			return expected_levels.size();
		endfunction
	endclass

endpackage

/* tb/tb_led_flash_pattern_generator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED flash pattern generator testbench
// Drives tick items and register writes, tracks the expected LED pattern and
// compares every result item field by field under random idling and stalls.
// ----------------------------------------------------------------------------
module tb_led_flash_pattern_generator;
	import lfpg_pkg::*;
	import led_pattern_check_pkg::*;

	// Index one past the last register; writes there must be ignored.
	localparam logic [1:0] REG_UNUSED = 2'd3;
	// Lowest and highest mode codes that name no pattern.
	localparam logic [MODE_WIDTH-1:0] MODE_UNUSED_LOW  = 4'd9;
	localparam logic [MODE_WIDTH-1:0] MODE_UNUSED_HIGH = 4'd15;
	localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
	// Cycles with no handshake of any kind before the run is declared hung.
	localparam int IDLE_LIMIT   = 5000;
	localparam int RANDOM_ITEMS = 1000;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  psel         = 1'b0;
	logic                  penable      = 1'b0;
	logic                  pwrite       = 1'b0;
	logic [ADDR_WIDTH-1:0] paddr        = '0;
	logic [DATA_WIDTH-1:0] pwdata       = '0;
	logic [DATA_WIDTH-1:0] prdata;
	logic                  pready;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	logic                  tick         = 1'b0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic                  led_level;
	logic                  level_updated;
	logic [STEP_WIDTH-1:0] pulse_step;

	led_pattern_tracker sb = new();

	int unsigned writes_done   = 0;
	int unsigned settings_run  = 0;
	int unsigned idle_cycles   = 0;
	int unsigned stall_left    = 0;
	int unsigned stall_style   = 0;
	int unsigned stall_phase   = 0;

	led_flash_pattern_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.tick         (tick),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.led_level    (led_level),
		.level_updated(level_updated),
		.pulse_step   (pulse_step)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Both handshakes are sampled at the rising edge, before the block's own
	// updates for that edge land, so every accepted item is seen exactly once.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				sb.note_tick(tick);
			if (result_valid && !result_stall)
				sb.check_level(led_level, level_updated, pulse_step);
		end
	end

	// The receiver switches at random between stall styles:
	// never stalling, light random stalls, heavy random stalls, and a fixed
	// duty pattern. This spreads the stalls over every phase of the pattern.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_style = $urandom_range(3, 0);
			stall_left  = $urandom_range(300, 50);
		end else begin
			stall_left = stall_left - 1;
		end
		stall_phase = stall_phase + 1;
		case (stall_style)
		0:       result_stall <= 1'b0;
		1:       result_stall <= ($urandom_range(3, 0) == 0);
		2:       result_stall <= ($urandom_range(9, 0) < 7);
		default: result_stall <= ((stall_phase % 16) < 10);
		endcase
	end

	// The watchdog restarts on any accepted item, result item or register
	// access. A hung handshake therefore ends the run as a failure.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(psel && penable))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// A write has a setup phase and then an access phase that lasts until
	// pready. The task then waits for an edge with psel low, so that
	// back-to-back writes never lower and raise psel within the same time step.
	task automatic write_register(input logic [1:0] index, input logic [DATA_WIDTH-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_WIDTH'({index, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_register(index, value);
		writes_done++;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Presents one item and holds it, unchanged, until the block takes it.
	task automatic send_item(input logic tick_in);
		item_valid <= 1'b1;
		tick       <= tick_in;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic wait_for_results();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Sends a run of items. With gaps enabled, the sender works in bursts of
	// random length with short random gaps between them; now and then it
	// also stops until everything sent so far has come back.
	task automatic send_items(input int count, input int tick_pct, input bit gappy);
		int burst;
		int gap;
		burst = $urandom_range(30, 1);
		for (int k = 0; k < count; k++) begin
			send_item($urandom_range(99, 0) < tick_pct);
			burst = burst - 1;
			if (k == count - 1) begin
				item_valid <= 1'b0;
			end else if (gappy && burst <= 0) begin
				gap = $urandom_range(8, 1);
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst = $urandom_range(30, 1);
			end else if ($urandom_range(199, 0) == 0) begin
				item_valid <= 1'b0;
				@(posedge clk);
				wait_for_results();
			end
		end
	endtask

	// Between settings the block must be idle: every result is back and
	// the result register has had time to settle.
	task automatic finish_setting();
		wait_for_results();
		repeat (2) @(posedge clk);
		settings_run++;
	endtask

	// Writes all three registers, with random bits above each field, then
	// sends a short run of ticks.
	task automatic directed_setting(input logic [MODE_WIDTH-1:0] mode_code,
			input logic [TIME_WIDTH-1:0] on_t, input logic [TIME_WIDTH-1:0] rep_t,
			input int count);
		write_register(REG_MODE, ($urandom() & ~32'hF) | DATA_WIDTH'(mode_code));
		write_register(REG_ON_TIME, ($urandom() & ~32'hFFFF) | DATA_WIDTH'(on_t));
		write_register(REG_REPEAT_TIME, ($urandom() & ~32'hFFFF) | DATA_WIDTH'(rep_t));
		send_items(count, 100, 1'b0);
		finish_setting();
	endtask

	// Durations are mostly short so that steps fire often and flash bursts
	// run to completion; a few are wide to exercise the upper bits.
	function automatic logic [TIME_WIDTH-1:0] pick_duration(input int short_max);
		int r;
		r = $urandom_range(99, 0);
		if (r < 75)
			return TIME_WIDTH'($urandom_range(short_max, 0));
		else if (r < 92)
			return TIME_WIDTH'($urandom_range(400, short_max + 1));
		else
			return TIME_WIDTH'($urandom());
	endfunction

	initial begin
		int                    random_items;
		int                    count;
		int                    tick_pct;
		logic [MODE_WIDTH-1:0] mode_code;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: the start item, then a sample-only item.
		send_items(2, 0, 1'b0);
		finish_setting();

		// Zero repeat time makes every tick step the pattern.
		directed_setting(MODE_ON, '0, '0, 2);

		// A write past the register list must not restart the sequence.
		write_register(REG_UNUSED, $urandom());
		send_items(1, 100, 1'b0);
		finish_setting();

		directed_setting(MODE_OFF, '0, TIME_MAX, 2);
		directed_setting(MODE_BLINK, '0, TIME_WIDTH'(1), 3);
		directed_setting(MODE_FLASH1, '0, '0, 2);
		// The rest gap would go negative here and has to clamp at zero.
		directed_setting(MODE_FLASH2, TIME_WIDTH'(1), TIME_WIDTH'(2), 2);
		directed_setting(MODE_FLASH3, TIME_MAX, TIME_MAX, 2);
		directed_setting(MODE_INV_FLASH1, '0, TIME_MAX, 2);
		directed_setting(MODE_INV_FLASH2, '0, '0, 2);
		directed_setting(MODE_INV_FLASH3, '0, '0, 2);
		// Unnamed mode codes still step, but leave level and interval alone.
		directed_setting(MODE_UNUSED_LOW, '0, '0, 2);
		directed_setting(MODE_UNUSED_HIGH, '0, '0, 1);

		// Random settings. Each register is rewritten most of the time; when
		// none is, the pattern carries on from where the last run stopped.
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(3, 0) != 0) begin
				mode_code = ($urandom_range(9, 0) == 0) ?
					MODE_WIDTH'($urandom_range(MODE_UNUSED_HIGH, MODE_UNUSED_LOW)) :
					MODE_WIDTH'($urandom_range(MODE_INV_FLASH3, MODE_OFF));
				write_register(REG_MODE, ($urandom() & ~32'hF) | DATA_WIDTH'(mode_code));
			end
			if ($urandom_range(3, 0) != 0)
				write_register(REG_ON_TIME, ($urandom() & ~32'hFFFF) |
					DATA_WIDTH'(pick_duration(5)));
			if ($urandom_range(3, 0) != 0)
				write_register(REG_REPEAT_TIME, ($urandom() & ~32'hFFFF) |
					DATA_WIDTH'(pick_duration(30)));
			if ($urandom_range(9, 0) == 0)
				write_register(REG_UNUSED, $urandom());
			case ($urandom_range(3, 0))
			0:       tick_pct = 100;
			1:       tick_pct = 90;
			2:       tick_pct = 60;
			default: tick_pct = 20;
			endcase
			count = $urandom_range(80, 10);
			send_items(count, tick_pct, $urandom_range(1, 0));
			random_items += count;
			finish_setting();
		end

		wait_for_results();
		repeat (4) @(posedge clk);
		if (sb.pending() != 0)
			$error("%0d expected results never arrived", sb.pending());

		$display("Run covered %0d items and %0d results over %0d settings (%0d register writes).",
			sb.items_noted, sb.results_checked, settings_run, writes_done);
		$display("The pattern stepped %0d times across every mode, unused codes included.",
			sb.steps_fired);
		if (sb.error_count == 0 && sb.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
